/* sv/rall_pkg.sv */
package rall_pkg;

  localparam int MAX_TYPES   = 8;
  localparam int MAX_PLAYERS = 16;
  localparam int QUEUE_DEPTH = 32;

  localparam int TYPE_W   = $clog2(MAX_TYPES);
  localparam int TCNT_W   = $clog2(MAX_TYPES + 1);
  localparam int PLAYER_W = 4;
  localparam int SYM_W    = 8;
  localparam int CNT_W    = 8;
  localparam int QIDX_W   = $clog2(QUEUE_DEPTH);
  localparam int QLEN_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int HADDR_W  = $clog2(MAX_PLAYERS * MAX_TYPES);
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 64;

  localparam logic [1:0] REG_TYPES = 2'd0;
  localparam logic [1:0] REG_SYMS  = 2'd1;
  localparam logic [1:0] REG_STOCK = 2'd2;

  localparam logic [1:0] KIND_ANSWER   = 2'd0;
  localparam logic [1:0] KIND_RETURNED = 2'd1;
  localparam logic [1:0] KIND_UNBLOCK  = 2'd2;
  localparam logic [1:0] KIND_SUMMARY  = 2'd3;

  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef struct packed {
    logic [PLAYER_W-1:0] player;
    logic [SYM_W-1:0]    symbol;
  } wait_entry_t;

  typedef enum logic [1:0] {
    Q_NONE,
    Q_PUSH,
    Q_POP,
    Q_RECYCLE
  } q_op_t;

  typedef struct packed {
    logic                 we;
    logic [HADDR_W-1:0]   waddr;
    logic [CNT_W-1:0]     wdata;
    logic [HADDR_W-1:0]   raddr;
  } held_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REQ,
    S_REQ_WR,
    S_DROP,
    S_TYPE_RD,
    S_TYPE_CHK,
    S_UB_LOOK,
    S_UB_WR,
    S_SUM
  } state_t;

  function automatic logic [SYM_W-1:0] upcase(input logic [SYM_W-1:0] s);
    logic [SYM_W-1:0] r;
    r = s;
    if (s >= 8'h61 && s <= 8'h7A) r = s - 8'd32;
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

/* sv/rall_held_mem.sv */
module rall_held_mem (
  input  logic                 clk,
  input  logic                 rst,
  input  rall_pkg::held_ctl_t  ctl,
  output logic [7:0]           rdata
);
  import rall_pkg::*;

  localparam int DEPTH = MAX_PLAYERS * MAX_TYPES;

  logic [CNT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [CNT_W-1:0] rd_q;
  logic             rv_q;

  always_ff @(posedge clk) begin
    if (ctl.we) mem[ctl.waddr] <= ctl.wdata;
    rd_q <= mem[ctl.raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rv_q  <= 1'b0;
    end else begin
      if (ctl.we) valid[ctl.waddr] <= 1'b1;
      rv_q <= valid[ctl.raddr];
    end
  end

  assign rdata = rv_q ? rd_q : '0;

endmodule

/* sv/rall_wait_q.sv */
module rall_wait_q (
  input  logic                   clk,
  input  logic                   rst,
  input  rall_pkg::q_op_t        op,
  input  rall_pkg::wait_entry_t  push_data,
  output rall_pkg::wait_entry_t  head,
  output logic [5:0]             length
);
  import rall_pkg::*;

  wait_entry_t entries [QUEUE_DEPTH];
  logic        full;

  assign full = (length == QLEN_W'(QUEUE_DEPTH));
  assign head = entries[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else begin
      case (op)
        Q_PUSH: if (!full) length <= length + 1'b1;
        Q_POP: if (length != '0) length <= length - 1'b1;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
    if (i < QUEUE_DEPTH - 1) begin : g_mid
      always_ff @(posedge clk) begin
        case (op)
          Q_PUSH: if (!full && length == QLEN_W'(i)) entries[i] <= push_data;
          Q_POP: entries[i] <= entries[i+1];
          Q_RECYCLE: begin
            if (length == QLEN_W'(i + 1)) entries[i] <= entries[0];
            else entries[i] <= entries[i+1];
          end
          default: ;
        endcase
      end
    end else begin : g_end
      always_ff @(posedge clk) begin
        case (op)
          Q_PUSH: if (!full && length == QLEN_W'(i)) entries[i] <= push_data;
          Q_RECYCLE: if (length == QLEN_W'(i + 1)) entries[i] <= entries[0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* sv/resource_allocator_wait_queue.sv */
// A request gives a single result: its answer, formed in S_REQ, or in S_REQ_WR when granted.
// A release first passes once over the wait queue to drop the player's waiters, then reads
// each type in use in turn; each held type adds one pass over the queue plus a write step
// (S_UB_WR) for each unblocked waiter, and a summary step (S_SUM) ends the release. Every
// result is registered before it shows on the ports, in the cycle after it is formed.
// One item is worked at a time; busy is high throughout, and results are one-cycle
// strobes that the receiver cannot stall. Reset is synchronous and needs no clearing pass.
module resource_allocator_wait_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [3:0]  player_id,
  input  logic [7:0]  resource_symbol,
  output logic        result_valid,
  output logic [1:0]  kind,
  output logic [3:0]  player_id_out,
  output logic [7:0]  symbol_out,
  output logic [7:0]  amount,
  output logic        granted,
  output logic        last
);
  import rall_pkg::*;

  state_t state, state_next;

  logic [3:0]          types_in_use;
  logic [63:0]         type_symbols;
  logic [63:0]         initial_stock;
  logic [CNT_W-1:0]    avail [MAX_TYPES];

  logic [PLAYER_W-1:0] pl;
  logic [SYM_W-1:0]    sym;
  logic [TCNT_W-1:0]   t;
  logic [CNT_W-1:0]    amt;
  logic [TCNT_W-1:0]   nret;
  logic [QLEN_W-1:0]   cnt;
  logic [QLEN_W-1:0]   rot_total;

  logic [TCNT_W-1:0]   nt;
  logic [SYM_W-1:0]    cur_sym;
  logic [CNT_W-1:0]    cur_avail;
  logic                hit;
  logic [TYPE_W-1:0]   hit_t;
  logic                cfg_we;
  logic                accept;
  logic                ub_grant;

  q_op_t               q_op;
  wait_entry_t         q_push;
  wait_entry_t         q_head;
  logic [QLEN_W-1:0]   q_len;
  held_ctl_t           hctl;
  logic [CNT_W-1:0]    held_rdata;

  logic                emit;
  logic [1:0]          e_kind;
  logic [PLAYER_W-1:0] e_pl;
  logic [SYM_W-1:0]    e_sym;
  logic [CNT_W-1:0]    e_amt;
  logic                e_gr;
  logic                e_last;

  rall_wait_q u_q (
    .clk(clk), .rst(rst), .op(q_op), .push_data(q_push), .head(q_head), .length(q_len)
  );

  rall_held_mem u_held (
    .clk(clk), .rst(rst), .ctl(hctl), .rdata(held_rdata)
  );

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign nt      = (types_in_use > 4'(MAX_TYPES)) ? TCNT_W'(MAX_TYPES) : types_in_use;
  assign cur_sym = type_symbols[8*t[TYPE_W-1:0] +: 8];
  assign cur_avail = avail[t[TYPE_W-1:0]];
  assign ub_grant = (cnt != rot_total) && (q_head.symbol == cur_sym) &&
                    (amt != '0) && (cur_avail != '0);

  always_comb begin
    case (paddr[4:3])
      REG_TYPES: prdata = {60'd0, types_in_use};
      REG_SYMS:  prdata = type_symbols;
      REG_STOCK: prdata = initial_stock;
      default:   prdata = '0;
    endcase
  end

  always_comb begin
    hit   = 1'b0;
    hit_t = '0;
    for (int i = MAX_TYPES - 1; i >= 0; i--) begin
      if (TCNT_W'(i) < nt && type_symbols[8*i +: 8] == sym && avail[i] != '0) begin
        hit   = 1'b1;
        hit_t = TYPE_W'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = (command == CMD_RELEASE) ? S_DROP : S_REQ;
      S_REQ: state_next = hit ? S_REQ_WR : S_IDLE;
      S_REQ_WR: state_next = S_IDLE;
      S_DROP: if (cnt == rot_total) state_next = S_TYPE_RD;
      S_TYPE_RD: state_next = (t >= nt) ? S_SUM : S_TYPE_CHK;
      S_TYPE_CHK: state_next = (held_rdata == '0) ? S_TYPE_RD : S_UB_LOOK;
      S_UB_LOOK: begin
        if (cnt == rot_total) state_next = S_TYPE_RD;
        else if (ub_grant) state_next = S_UB_WR;
      end
      S_UB_WR: state_next = S_UB_LOOK;
      S_SUM: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_op   = Q_NONE;
    q_push = '{player: pl, symbol: sym};
    hctl   = '{we: 1'b0, waddr: {pl, t[TYPE_W-1:0]}, wdata: '0,
               raddr: {pl, t[TYPE_W-1:0]}};
    emit   = 1'b0;
    e_kind = KIND_ANSWER;
    e_pl   = pl;
    e_sym  = sym;
    e_amt  = '0;
    e_gr   = 1'b0;
    e_last = 1'b0;
    case (state)
      S_REQ: begin
        hctl.raddr = {pl, hit_t};
        if (!hit) begin
          q_op   = Q_PUSH;
          emit   = 1'b1;
          e_last = 1'b1;
        end
      end
      S_REQ_WR: begin
        hctl.we    = 1'b1;
        hctl.wdata = sat_add(held_rdata, 8'd1);
        emit       = 1'b1;
        e_gr       = 1'b1;
        e_last     = 1'b1;
      end
      S_DROP: begin
        if (cnt != rot_total) q_op = (q_head.player == pl) ? Q_POP : Q_RECYCLE;
      end
      S_TYPE_CHK: begin
        if (held_rdata != '0) begin
          hctl.we = 1'b1;
          emit    = 1'b1;
          e_kind  = KIND_RETURNED;
          e_sym   = cur_sym;
          e_amt   = held_rdata;
        end
      end
      S_UB_LOOK: begin
        hctl.raddr = {q_head.player, t[TYPE_W-1:0]};
        if (cnt != rot_total && !ub_grant) q_op = Q_RECYCLE;
      end
      S_UB_WR: begin
        q_op       = Q_POP;
        hctl.we    = 1'b1;
        hctl.waddr = {q_head.player, t[TYPE_W-1:0]};
        hctl.wdata = sat_add(held_rdata, 8'd1);
        emit       = 1'b1;
        e_kind     = KIND_UNBLOCK;
        e_pl       = q_head.player;
        e_sym      = cur_sym;
      end
      S_SUM: begin
        emit   = 1'b1;
        e_kind = KIND_SUMMARY;
        e_sym  = '0;
        e_amt  = CNT_W'(nret);
        e_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      types_in_use <= 4'(MAX_TYPES);
      type_symbols <= '0;
      initial_stock <= '0;
      for (int i = 0; i < MAX_TYPES; i++) avail[i] <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= emit;
      if (cfg_we) begin
        case (paddr[4:3])
          REG_TYPES: types_in_use <= pwdata[3:0];
          REG_SYMS:  type_symbols <= pwdata;
          REG_STOCK: begin
            initial_stock <= pwdata;
            for (int i = 0; i < MAX_TYPES; i++) avail[i] <= pwdata[8*i +: 8];
          end
          default: ;
        endcase
      end else begin
        case (state)
          S_REQ: if (hit) avail[hit_t] <= avail[hit_t] - 1'b1;
          S_TYPE_CHK: begin
            if (held_rdata != '0) avail[t[TYPE_W-1:0]] <= sat_add(cur_avail, held_rdata);
          end
          S_UB_WR: avail[t[TYPE_W-1:0]] <= cur_avail - 1'b1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    kind          <= e_kind;
    player_id_out <= e_pl;
    symbol_out    <= e_sym;
    amount        <= e_amt;
    granted       <= e_gr;
    last          <= e_last;
    case (state)
      S_IDLE: begin
        pl        <= player_id;
        sym       <= upcase(resource_symbol);
        cnt       <= '0;
        rot_total <= q_len;
        t         <= '0;
        nret      <= '0;
      end
      S_REQ: t <= TCNT_W'(hit_t);
      S_DROP: if (cnt != rot_total) cnt <= cnt + 1'b1;
      S_TYPE_CHK: begin
        if (held_rdata == '0) begin
          t <= t + 1'b1;
        end else begin
          amt       <= held_rdata;
          nret      <= nret + 1'b1;
          cnt       <= '0;
          rot_total <= q_len;
        end
      end
      S_UB_LOOK: begin
        if (cnt == rot_total) t <= t + 1'b1;
        else if (!ub_grant) cnt <= cnt + 1'b1;
      end
      S_UB_WR: begin
        amt <= amt - 1'b1;
        cnt <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* sv/rall_checker.sv */
module rall_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       result_valid,
  input logic [1:0] kind,
  input logic [7:0] symbol_out,
  input logic       granted,
  input logic       last
);
  import rall_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy did not rise after an accepted item");

  a_answer_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_ANSWER |-> last)
    else $error("request answer not marked last");

  a_summary_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_SUMMARY |-> last && symbol_out == 8'd0 && !granted)
    else $error("malformed release summary");

  a_release_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == KIND_RETURNED || kind == KIND_UNBLOCK) |-> !last && !granted)
    else $error("intermediate release result marked last or granted");

endmodule

bind resource_allocator_wait_queue rall_checker u_rall_checker (.*);

/* tb/resource_allocator_wait_queue_tb.sv */
module resource_allocator_wait_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rall_pkg::*;

  typedef struct {
    logic       cmd;
    logic [3:0] player;
    logic [7:0] symbol;
  } alloc_cmd_t;

  typedef struct {
    logic [1:0] kind;
    logic [3:0] player;
    logic [7:0] symbol;
    logic [7:0] amount;
    logic       granted;
    logic       last;
  } alloc_result_t;

  typedef struct {
    logic [3:0] player;
    logic [7:0] symbol;
  } waiter_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic        command = CMD_REQUEST;
  logic [3:0]  player_id = '0;
  logic [7:0]  resource_symbol = '0;
  logic        result_valid;
  logic [1:0]  kind;
  logic [3:0]  player_id_out;
  logic [7:0]  symbol_out;
  logic [7:0]  amount;
  logic        granted;
  logic        last;

  resource_allocator_wait_queue u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the allocator state and its configuration.
  logic [3:0]    cfg_types = 4'd8;
  logic [63:0]   cfg_symbols = '0;
  logic [7:0]    stock_left [MAX_TYPES];
  logic [7:0]    units_held [MAX_PLAYERS][MAX_TYPES];
  waiter_t       waiters[$];

  alloc_cmd_t    pending_cmds[$];
  alloc_result_t expected_results[$];

  int  errors = 0;
  int  cmds_done = 0;
  int  results_seen = 0;
  int  releases_done = 0;
  int  unblocks_seen = 0;
  int  grants_seen = 0;
  int  gap_left = 0;
  bit  steady_feed = 0;

  function automatic void push_result(logic [1:0] k, logic [3:0] p, logic [7:0] s,
                                      logic [7:0] a, logic g, logic l);
    alloc_result_t r;
    r.kind = k;
    r.player = p;
    r.symbol = s;
    r.amount = a;
    r.granted = g;
    r.last = l;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_allocation(alloc_cmd_t c);
    int         nt;
    int         k;
    logic [7:0] sym;
    logic [7:0] units;
    logic [7:0] ret_types;
    logic [8:0] sum;
    logic       gr;
    waiter_t    kept[$];
    nt = (cfg_types > 8) ? 8 : int'(cfg_types);
    if (c.cmd == CMD_REQUEST) begin
      sym = c.symbol;
      if (sym >= 8'h61 && sym <= 8'h7A) sym = sym - 8'd32;
      gr = 1'b0;
      for (int t = 0; t < nt; t++) begin
        if (cfg_symbols[8*t +: 8] == sym && stock_left[t] > 0) begin
          stock_left[t]--;
          if (units_held[c.player][t] != 8'hFF) units_held[c.player][t]++;
          gr = 1'b1;
          break;
        end
      end
      if (!gr && waiters.size() < QUEUE_DEPTH) waiters.push_back('{c.player, sym});
      push_result(KIND_ANSWER, c.player, sym, 8'd0, gr, 1'b1);
      return;
    end
    foreach (waiters[i]) if (waiters[i].player != c.player) kept.push_back(waiters[i]);
    waiters = kept;
    ret_types = 0;
    for (int t = 0; t < nt; t++) begin
      units = units_held[c.player][t];
      sym = cfg_symbols[8*t +: 8];
      if (units == 0) continue;
      ret_types++;
      units_held[c.player][t] = 0;
      sum = {1'b0, stock_left[t]} + {1'b0, units};
      stock_left[t] = sum[8] ? 8'hFF : sum[7:0];
      push_result(KIND_RETURNED, c.player, sym, units, 1'b0, 1'b0);
      k = 0;
      while (units > 0 && stock_left[t] > 0 && k < waiters.size()) begin
        if (waiters[k].symbol == sym) begin
          if (units_held[waiters[k].player][t] != 8'hFF)
            units_held[waiters[k].player][t]++;
          stock_left[t]--;
          units--;
          push_result(KIND_UNBLOCK, waiters[k].player, sym, 8'd0, 1'b0, 1'b0);
          waiters.delete(k);
        end else begin
          k++;
        end
      end
    end
    push_result(KIND_SUMMARY, c.player, 8'd0, ret_types, 1'b0, 1'b1);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_feed || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    alloc_cmd_t c;
    if (!rst) begin
      if (start && !busy) begin
        c.cmd = command;
        c.player = player_id;
        c.symbol = resource_symbol;
        predict_allocation(c);
        cmds_done++;
        if (command == CMD_RELEASE) releases_done++;
      end
      if (start && busy) begin
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        start <= 1'b1;
        command <= c.cmd;
        player_id <= c.player;
        resource_symbol <= c.symbol;
        gap_left = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst && result_valid) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d player %0d", kind, player_id_out);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, kind);
          errors++;
        end
        if (player_id_out !== e.player) begin
          $error("player_id_out: expected %0d, got %0d", e.player, player_id_out);
          errors++;
        end
        if (symbol_out !== e.symbol) begin
          $error("symbol_out: expected %h, got %h", e.symbol, symbol_out);
          errors++;
        end
        if (amount !== e.amount) begin
          $error("amount: expected %0d, got %0d", e.amount, amount);
          errors++;
        end
        if (granted !== e.granted) begin
          $error("granted: expected %0d, got %0d", e.granted, granted);
          errors++;
        end
        if (last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, last);
          errors++;
        end
        if (e.kind == KIND_UNBLOCK) unblocks_seen++;
        if (e.kind == KIND_ANSWER && e.granted) grants_seen++;
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TYPES: cfg_types = value[3:0];
      REG_SYMS: cfg_symbols = value;
      REG_STOCK: begin
        for (int t = 0; t < MAX_TYPES; t++) stock_left[t] = value[8*t +: 8];
      end
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_cmds.size() > 0 || start || expected_results.size() > 0);
    repeat (5) @(posedge clk);
  endtask

  task automatic add_cmd(logic cmd, logic [3:0] p, logic [7:0] s);
    pending_cmds.push_back('{cmd, p, s});
  endtask

  function automatic logic [7:0] any_symbol();
    logic [7:0] s;
    int         nt;
    nt = (cfg_types > 8) ? 8 : int'(cfg_types);
    if (nt == 0 || $urandom_range(0, 4) == 0) return $urandom_range(0, 255);
    s = cfg_symbols[8*$urandom_range(0, nt - 1) +: 8];
    if (s >= 8'h41 && s <= 8'h5A && $urandom_range(0, 1)) s = s + 8'd32;
    return s;
  endfunction

  task automatic random_cmds(int n);
    logic [3:0] p;
    repeat (n) begin
      p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 5);
      add_cmd(($urandom_range(0, 4) == 0) ? CMD_RELEASE : CMD_REQUEST, p, any_symbol());
    end
  endtask

  function automatic logic [63:0] letter_set();
    logic [63:0] v;
    for (int t = 0; t < 8; t++)
      v[8*t +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'h41 + 8'($urandom_range(0, 7));
    return v;
  endfunction

  function automatic logic [63:0] small_stock();
    logic [63:0] v;
    for (int t = 0; t < 8; t++) v[8*t +: 8] = $urandom_range(0, 3);
    return v;
  endfunction

  initial begin
    foreach (stock_left[t]) stock_left[t] = 0;
    foreach (units_held[p, t]) units_held[p][t] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    reg_write(REG_TYPES, 64'd3);
    reg_write(REG_SYMS, 64'h0000_0000_0043_4241);
    reg_write(REG_STOCK, 64'h0000_0000_0000_0102);
    add_cmd(CMD_REQUEST, 4'd0, 8'h61);
    add_cmd(CMD_REQUEST, 4'd1, 8'h41);
    add_cmd(CMD_REQUEST, 4'd2, 8'h41);
    add_cmd(CMD_REQUEST, 4'd15, 8'h63);
    add_cmd(CMD_REQUEST, 4'd3, 8'h62);
    add_cmd(CMD_REQUEST, 4'd4, 8'hFF);
    add_cmd(CMD_REQUEST, 4'd5, 8'h00);
    add_cmd(CMD_REQUEST, 4'd6, 8'h7A);
    add_cmd(CMD_RELEASE, 4'd0, 8'hFF);
    add_cmd(CMD_RELEASE, 4'd9, 8'h00);
    for (int i = 0; i < 34; i++) add_cmd(CMD_REQUEST, 4'(i), 8'h43);
    add_cmd(CMD_RELEASE, 4'd15, 8'h41);
    add_cmd(CMD_RELEASE, 4'd3, 8'h42);
    wait_drained();

    reg_write(REG_TYPES, 64'd0);
    add_cmd(CMD_REQUEST, 4'd7, 8'h41);
    add_cmd(CMD_RELEASE, 4'd1, 8'h00);
    wait_drained();

    reg_write(REG_TYPES, 64'd15);
    reg_write(REG_SYMS, 64'h4141_4242_4141_4343);
    reg_write(REG_STOCK, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cmd(CMD_REQUEST, 4'd8, 8'h41);
    add_cmd(CMD_REQUEST, 4'd8, 8'h61);
    wait_drained();
    reg_write(REG_STOCK, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cmd(CMD_RELEASE, 4'd8, 8'h00);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      steady_feed = (ph % 3 == 1);
      reg_write(REG_TYPES, (ph == 0) ? 64'd1 : (ph == 7) ? 64'd8 : 64'($urandom_range(0, 15)));
      reg_write(REG_SYMS, letter_set());
      reg_write(REG_STOCK, (ph == 5) ? 64'($urandom) << 32 | 64'($urandom) : small_stock());
      random_cmds(34);
      for (int p = 0; p < 16; p++) add_cmd(CMD_RELEASE, 4'(p), 8'($urandom_range(0, 255)));
      wait_drained();
    end

    repeat (50) @(posedge clk);
    $display("Ran %0d items (%0d releases) giving %0d results: %0d grants, %0d unblocks.",
             cmds_done, releases_done, results_seen, grants_seen, unblocks_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out waiting for the allocator.");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* resource_allocator_wait_queue.f */
sv/rall_pkg.sv
sv/rall_held_mem.sv
sv/rall_wait_q.sv
sv/resource_allocator_wait_queue.sv
sv/rall_checker.sv
tb/resource_allocator_wait_queue_tb.sv
